@@ design/rpmc_pkg.sv @@
// ----------------------------------------------------------------------------
// rpmc_pkg
// Shared types, register indexes and constants of the ray probe mask
// clearance unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rpmc_pkg;

    // Default sizes of the mask and of the sample run.
    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int MAX_HEIGHT_DEF  = 1024;
    localparam int MAX_SAMPLES_DEF = 64;

    // A pixel byte above this level is stored as bright.
    localparam logic [7:0] BRIGHT_LEVEL = 8'd128;

    // Width of the shared compare and subtract unit.
    localparam int ACC_W = 48;

    // Iteration counts of the square root and of the divider.
    localparam int SQRT_STEPS = 24;
    localparam int DIV_STEPS  = 16;

    // Request kinds.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_PROBE = 1'b1;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_CENTER_X   = 3'd0,
        CFG_CENTER_Y   = 3'd1,
        CFG_EXT_DIST   = 3'd2,
        CFG_SAMPLE_CNT = 3'd3,
        CFG_IMG_WIDTH  = 3'd4,
        CFG_IMG_HEIGHT = 3'd5
    } t_cfg_idx;

    // Which quotient the divider is producing.
    typedef enum logic [1:0] {
        JOB_ENDX = 2'd0,
        JOB_ENDY = 2'd1,
        JOB_SX   = 2'd2,
        JOB_SY   = 2'd3
    } t_job;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_SQX   = 12'b0000_0000_0010,
        S_SQY   = 12'b0000_0000_0100,
        S_SQRT  = 12'b0000_0000_1000,
        S_MX    = 12'b0000_0001_0000,
        S_MY    = 12'b0000_0010_0000,
        S_MN    = 12'b0000_0100_0000,
        S_DINIT = 12'b0000_1000_0000,
        S_DIV   = 12'b0001_0000_0000,
        S_POST  = 12'b0010_0000_0000,
        S_ADDR  = 12'b0100_0000_0000,
        S_READ  = 12'b1000_0000_0000
    } t_state_a;

    // Outcome of one compare and subtract step.
    typedef struct packed {
        logic             ge;
        logic [ACC_W-1:0] diff;
    } t_cs_res;

endpackage

`default_nettype wire

@@ design/ray_probe_mask_clearance_unit.sv @@
// ----------------------------------------------------------------------------
// ray_probe_mask_clearance_unit
// Keeps a one-bit mask of bright pixels and probes the mask along the
// extension of a line from the configured centre through an endpoint.
// ----------------------------------------------------------------------------
// A write transaction stores one mask pixel, so writes may stream back to
// back while no probe holds the input stall. A probe transaction holds the
// input stall high until its result has been loaded into the output register,
// and one whose endpoint equals the centre skips the arithmetic. The probe
// runs on one shared 48-bit compare and subtract unit: it runs 24 steps of the
// square root of the squared length, then 16 steps of restoring division for
// each of the two end coordinates and for both coordinates of every sample,
// and each sample inside the image then needs a registered read of the mask
// memory. A probe ends early at the first bright sample. The mask memory is
// not cleared after reset; pixels must be written before a probe visits them.
// Configuration must be written only while no probe is in flight; the block
// does not enforce this, and the write channel is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_probe_mask_clearance_unit #(
    parameter int MAX_WIDTH   = rpmc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = rpmc_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_SAMPLES = rpmc_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    // Request channel.
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_req_type,
    input  wire logic        [9:0]  i_pixel_col,
    input  wire logic        [9:0]  i_pixel_row,
    input  wire logic        [7:0]  i_pixel_value,
    input  wire logic signed [14:0] i_endpoint_x,
    input  wire logic signed [14:0] i_endpoint_y,

    // Result channel.
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_is_clear,
    output logic                    o_degenerate,
    output logic signed      [17:0] o_end_x,
    output logic signed      [17:0] o_end_y,

    // Configuration write channel.
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic        [2:0]  i_cfg_index,
    input  wire logic        [13:0] i_cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int AccW  = rpmc_pkg::ACC_W;

    // The eval and done states sit outside the package enum so that the one-hot
    // state word keeps a single type.
    typedef enum logic [13:0] {
        ST_IDLE  = 14'b00_0000_0000_0001,
        ST_SQX   = 14'b00_0000_0000_0010,
        ST_SQY   = 14'b00_0000_0000_0100,
        ST_SQRT  = 14'b00_0000_0000_1000,
        ST_MX    = 14'b00_0000_0001_0000,
        ST_MY    = 14'b00_0000_0010_0000,
        ST_MN    = 14'b00_0000_0100_0000,
        ST_DINIT = 14'b00_0000_1000_0000,
        ST_DIV   = 14'b00_0001_0000_0000,
        ST_POST  = 14'b00_0010_0000_0000,
        ST_ADDR  = 14'b00_0100_0000_0000,
        ST_READ  = 14'b00_1000_0000_0000,
        ST_EVAL  = 14'b01_0000_0000_0000,
        ST_DONE  = 14'b10_0000_0000_0000
    } t_state;

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    t_state              r_state, n_state;
    logic                r_out_valid, n_out_valid;

    logic [13:0]         r_center_x, r_center_y;
    logic [10:0]         r_ext_dist;
    logic [6:0]          r_sample_cnt;
    logic [10:0]         r_img_width, r_img_height;

    logic signed [14:0]  r_ex, n_ex, r_ey, n_ey;
    logic [15:0]         r_ax, n_ax, r_ay, n_ay;
    logic                r_negx, n_negx, r_negy, n_negy;
    logic [6:0]          r_n, n_n, r_i, n_i;
    logic [10:0]         r_w, n_w, r_h, n_h;
    logic [31:0]         r_s, n_s;
    logic [AccW-1:0]     r_rem, n_rem, r_res, n_res, r_bit, n_bit, r_dsh, n_dsh;
    logic [4:0]          r_cnt, n_cnt;
    logic [23:0]         r_len, n_len;
    logic [27:0]         r_stepx, n_stepx, r_stepy, n_stepy;
    logic [30:0]         r_den, n_den;
    logic [33:0]         r_accx, n_accx, r_accy, n_accy;
    logic [15:0]         r_q, n_q;
    rpmc_pkg::t_job      r_job, n_job;
    logic [17:0]         r_px, n_px, r_py, n_py;
    logic [17:0]         r_endx, n_endx, r_endy, n_endy;
    logic                r_clear, n_clear, r_degen, n_degen;
    logic [AW-1:0]       r_addr, n_addr;

    logic                r_o_clear, n_o_clear, r_o_degen, n_o_degen;
    logic [17:0]         r_o_endx, n_o_endx, r_o_endy, n_o_endy;

    // ------------------------------------------------------------------
    // Handshakes.
    // ------------------------------------------------------------------
    logic in_acc;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Mask memory. Writes go straight in at the accepting edge.
    // ------------------------------------------------------------------
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_rdata;

    assign ram_we = in_acc && (i_req_type == rpmc_pkg::REQ_WRITE)
                    && (32'(i_pixel_col) < 32'(MAX_WIDTH))
                    && (32'(i_pixel_row) < 32'(MAX_HEIGHT));
    assign ram_waddr = AW'(32'(i_pixel_row) * 32'(MAX_WIDTH) + 32'(i_pixel_col));

    rpmc_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_mask (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_pixel_value > rpmc_pkg::BRIGHT_LEVEL),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Shared compare and subtract unit. The square root compares the
    // remainder with root plus bit; the divider with the shifted divisor.
    // ------------------------------------------------------------------
    logic [AccW-1:0]   cs_b;
    rpmc_pkg::t_cs_res cs_res;

    assign cs_b = (r_state == ST_SQRT) ? (r_res + r_bit) : r_dsh;

    rpmc_cmpsub u_cmpsub (
        .i_a   (r_rem),
        .i_b   (cs_b),
        .o_res (cs_res)
    );

    // ------------------------------------------------------------------
    // Shared multiplier for squares, per-sample steps and the divisor.
    // ------------------------------------------------------------------
    logic [23:0] mul_a;
    logic [16:0] mul_b;
    logic [40:0] mul_p;

    always_comb begin
        mul_a = 24'(r_ax);
        mul_b = 17'(r_ax);
        case (r_state)
            ST_SQY: begin
                mul_a = 24'(r_ay);
                mul_b = 17'(r_ay);
            end
            ST_MX: begin
                mul_b = 17'(r_ext_dist);
            end
            ST_MY: begin
                mul_a = 24'(r_ay);
                mul_b = 17'(r_ext_dist);
            end
            ST_MN: begin
                mul_a = r_len;
                mul_b = 17'(r_n);
            end
            default: begin
                mul_a = 24'(r_ax);
                mul_b = 17'(r_ax);
            end
        endcase
    end

    assign mul_p = 41'(mul_a) * 41'(mul_b);

    // ------------------------------------------------------------------
    // Combinational helpers.
    // ------------------------------------------------------------------
    logic signed [16:0] dx_in, dy_in;
    logic [16:0]        adx_in, ady_in;
    logic               is_end_job, is_x_job;
    logic [30:0]        den_sel;
    logic [AccW-1:0]    num_sel;
    logic [17:0]        q_signed, base_sel, pos_sum;
    logic [16:0]        px_rnd, py_rnd;
    logic [12:0]        pix_x, pix_y;
    logic               in_image;

    assign dx_in  = 17'(i_endpoint_x) - $signed({3'b000, r_center_x});
    assign dy_in  = 17'(i_endpoint_y) - $signed({3'b000, r_center_y});
    assign adx_in = dx_in[16] ? 17'(-dx_in) : 17'(dx_in);
    assign ady_in = dy_in[16] ? 17'(-dy_in) : 17'(dy_in);

    assign is_end_job = (r_job == rpmc_pkg::JOB_ENDX) || (r_job == rpmc_pkg::JOB_ENDY);
    assign is_x_job   = (r_job == rpmc_pkg::JOB_ENDX) || (r_job == rpmc_pkg::JOB_SX);

    // End offsets divide by the length, sample offsets by n times the length.
    assign den_sel = is_end_job ? 31'(r_len) : r_den;

    always_comb begin
        case (r_job)
            rpmc_pkg::JOB_ENDX: num_sel = AccW'({r_stepx, 12'd0});
            rpmc_pkg::JOB_ENDY: num_sel = AccW'({r_stepy, 12'd0});
            rpmc_pkg::JOB_SX:   num_sel = AccW'({r_accx, 12'd0});
            rpmc_pkg::JOB_SY:   num_sel = AccW'({r_accy, 12'd0});
            default:            num_sel = '0;
        endcase
    end

    // The quotient takes the sign of the direction component; the sum never
    // leaves the 18-bit range, so no saturation stage is needed.
    assign q_signed = (is_x_job ? r_negx : r_negy) ? 18'(-{2'b00, r_q}) : {2'b00, r_q};
    assign base_sel = is_x_job ? 18'(r_ex) : 18'(r_ey);
    assign pos_sum  = base_sel + q_signed;

    // Round a non-negative position to its pixel, ties upward.
    assign px_rnd = r_px[16:0] + 17'd8;
    assign py_rnd = r_py[16:0] + 17'd8;
    assign pix_x  = px_rnd[16:4];
    assign pix_y  = py_rnd[16:4];
    assign in_image = !r_px[17] && !r_py[17]
                      && (13'(pix_x) < 13'(r_w)) && (13'(pix_y) < 13'(r_h));

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_ex = r_ex;       n_ey = r_ey;
        n_ax = r_ax;       n_ay = r_ay;
        n_negx = r_negx;   n_negy = r_negy;
        n_n = r_n;         n_i = r_i;
        n_w = r_w;         n_h = r_h;
        n_s = r_s;
        n_rem = r_rem;     n_res = r_res;
        n_bit = r_bit;     n_dsh = r_dsh;
        n_cnt = r_cnt;     n_len = r_len;
        n_stepx = r_stepx; n_stepy = r_stepy;
        n_den = r_den;
        n_accx = r_accx;   n_accy = r_accy;
        n_q = r_q;         n_job = r_job;
        n_px = r_px;       n_py = r_py;
        n_endx = r_endx;   n_endy = r_endy;
        n_clear = r_clear; n_degen = r_degen;
        n_addr = r_addr;
        n_o_clear = r_o_clear; n_o_degen = r_o_degen;
        n_o_endx = r_o_endx;   n_o_endy = r_o_endy;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_req_type == rpmc_pkg::REQ_PROBE)) begin
                    n_ex   = i_endpoint_x;
                    n_ey   = i_endpoint_y;
                    n_ax   = adx_in[15:0];
                    n_ay   = ady_in[15:0];
                    n_negx = dx_in[16];
                    n_negy = dy_in[16];
                    n_n    = (32'(r_sample_cnt) > 32'(MAX_SAMPLES))
                             ? 7'(MAX_SAMPLES) : r_sample_cnt;
                    n_w    = (32'(r_img_width) > 32'(MAX_WIDTH))
                             ? 11'(MAX_WIDTH) : r_img_width;
                    n_h    = (32'(r_img_height) > 32'(MAX_HEIGHT))
                             ? 11'(MAX_HEIGHT) : r_img_height;
                    n_endx = 18'(i_endpoint_x);
                    n_endy = 18'(i_endpoint_y);
                    if ((dx_in == 17'sd0) && (dy_in == 17'sd0)) begin
                        // No direction: report the endpoint and no clearance.
                        n_degen = 1'b1;
                        n_clear = 1'b0;
                        n_state = ST_DONE;
                    end else begin
                        n_degen = 1'b0;
                        n_clear = 1'b1;
                        n_state = ST_SQX;
                    end
                end
            end
            ST_SQX: begin
                n_s     = 32'(mul_p);
                n_state = ST_SQY;
            end
            ST_SQY: begin
                n_rem   = AccW'({r_s + 32'(mul_p), 16'd0});
                n_res   = '0;
                n_bit   = AccW'(1) << (AccW - 2);
                n_cnt   = '0;
                n_state = ST_SQRT;
            end
            ST_SQRT: begin
                if (cs_res.ge) begin
                    n_rem = cs_res.diff;
                    n_res = (r_res >> 1) + r_bit;
                end else begin
                    n_res = r_res >> 1;
                end
                n_bit = r_bit >> 2;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(rpmc_pkg::SQRT_STEPS - 1)) begin
                    n_state = ST_MX;
                end
            end
            ST_MX: begin
                n_len   = r_res[23:0];
                n_stepx = 28'(mul_p);
                n_state = ST_MY;
            end
            ST_MY: begin
                n_stepy = 28'(mul_p);
                n_state = ST_MN;
            end
            ST_MN: begin
                n_den   = 31'(mul_p);
                n_job   = rpmc_pkg::JOB_ENDX;
                n_state = ST_DINIT;
            end
            ST_DINIT: begin
                // Adding half the divisor gives round to nearest, ties away.
                n_rem   = num_sel + AccW'(den_sel >> 1);
                n_dsh   = AccW'(den_sel) << (rpmc_pkg::DIV_STEPS - 1);
                n_q     = '0;
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (cs_res.ge) begin
                    n_rem = cs_res.diff;
                end
                n_q   = {r_q[14:0], cs_res.ge};
                n_dsh = r_dsh >> 1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(rpmc_pkg::DIV_STEPS - 1)) begin
                    n_state = ST_POST;
                end
            end
            ST_POST: begin
                case (r_job)
                    rpmc_pkg::JOB_ENDX: begin
                        n_endx  = pos_sum;
                        n_job   = rpmc_pkg::JOB_ENDY;
                        n_state = ST_DINIT;
                    end
                    rpmc_pkg::JOB_ENDY: begin
                        n_endy = pos_sum;
                        if (r_n == 7'd0) begin
                            n_state = ST_DONE;
                        end else begin
                            n_i     = 7'd1;
                            n_accx  = 34'(r_stepx);
                            n_accy  = 34'(r_stepy);
                            n_job   = rpmc_pkg::JOB_SX;
                            n_state = ST_DINIT;
                        end
                    end
                    rpmc_pkg::JOB_SX: begin
                        n_px    = pos_sum;
                        n_job   = rpmc_pkg::JOB_SY;
                        n_state = ST_DINIT;
                    end
                    default: begin
                        n_py    = pos_sum;
                        n_state = ST_ADDR;
                    end
                endcase
            end
            ST_ADDR, ST_EVAL: begin
                if ((r_state == ST_ADDR) && in_image) begin
                    n_addr  = AW'(32'(pix_y) * 32'(MAX_WIDTH) + 32'(pix_x));
                    n_state = ST_READ;
                end else if ((r_state == ST_EVAL) && ram_rdata) begin
                    n_clear = 1'b0;
                    n_state = ST_DONE;
                end else if (r_i == r_n) begin
                    n_state = ST_DONE;
                end else begin
                    n_i     = r_i + 7'd1;
                    n_accx  = r_accx + 34'(r_stepx);
                    n_accy  = r_accy + 34'(r_stepy);
                    n_job   = rpmc_pkg::JOB_SX;
                    n_state = ST_DINIT;
                end
            end
            ST_READ: begin
                n_state = ST_EVAL;
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_clear   = r_clear;
                    n_o_degen   = r_degen;
                    n_o_endx    = r_endx;
                    n_o_endy    = r_endy;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers and configuration.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_center_x   <= 14'd0;
            r_center_y   <= 14'd0;
            r_ext_dist   <= 11'd1000;
            r_sample_cnt <= 7'd50;
            r_img_width  <= 11'd640;
            r_img_height <= 11'd480;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    rpmc_pkg::CFG_CENTER_X:   r_center_x   <= i_cfg_data;
                    rpmc_pkg::CFG_CENTER_Y:   r_center_y   <= i_cfg_data;
                    rpmc_pkg::CFG_EXT_DIST:   r_ext_dist   <= i_cfg_data[10:0];
                    rpmc_pkg::CFG_SAMPLE_CNT: r_sample_cnt <= i_cfg_data[6:0];
                    rpmc_pkg::CFG_IMG_WIDTH:  r_img_width  <= i_cfg_data[10:0];
                    rpmc_pkg::CFG_IMG_HEIGHT: r_img_height <= i_cfg_data[10:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_ex <= n_ex;       r_ey <= n_ey;
        r_ax <= n_ax;       r_ay <= n_ay;
        r_negx <= n_negx;   r_negy <= n_negy;
        r_n <= n_n;         r_i <= n_i;
        r_w <= n_w;         r_h <= n_h;
        r_s <= n_s;
        r_rem <= n_rem;     r_res <= n_res;
        r_bit <= n_bit;     r_dsh <= n_dsh;
        r_cnt <= n_cnt;     r_len <= n_len;
        r_stepx <= n_stepx; r_stepy <= n_stepy;
        r_den <= n_den;
        r_accx <= n_accx;   r_accy <= n_accy;
        r_q <= n_q;         r_job <= n_job;
        r_px <= n_px;       r_py <= n_py;
        r_endx <= n_endx;   r_endy <= n_endy;
        r_clear <= n_clear; r_degen <= n_degen;
        r_addr <= n_addr;
        r_o_clear <= n_o_clear; r_o_degen <= n_o_degen;
        r_o_endx <= n_o_endx;   r_o_endy <= n_o_endy;
    end

    assign o_out_valid  = r_out_valid;
    assign o_is_clear   = r_o_clear;
    assign o_degenerate = r_o_degen;
    assign o_end_x      = $signed(r_o_endx);
    assign o_end_y      = $signed(r_o_endy);

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A degenerate probe can never be reported as clear.
    a_degen_not_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_degenerate && o_is_clear))
        else $error("degenerate result reported as clear");

    // A new result only appears on leaving the done state.
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result raised outside the done state");

    // A mask read always belongs to a sample within the run.
    a_sample_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EVAL) |-> ((r_i != 7'd0) && (r_i <= r_n)))
        else $error("sample index outside the run");

endmodule

`default_nettype wire

@@ design/rpmc_ram.sv @@
// ----------------------------------------------------------------------------
// rpmc_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rpmc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ design/rpmc_cmpsub.sv @@
// ----------------------------------------------------------------------------
// rpmc_cmpsub
// Shared compare and subtract unit, stepped by the square root and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module rpmc_cmpsub (
    input  wire logic [rpmc_pkg::ACC_W-1:0] i_a,
    input  wire logic [rpmc_pkg::ACC_W-1:0] i_b,
    output rpmc_pkg::t_cs_res               o_res
);

    // The difference is always formed; the caller takes it only when the minuend is not below the subtrahend.
    always_comb begin
        o_res.ge   = (i_a >= i_b);
        o_res.diff = i_a - i_b;
    end

endmodule

`default_nettype wire
